FILE: hw/rtl/gbkf_pkg.sv
// gbkf_pkg: shared types, register indexes, slot codes and the micro-program
// of the gyro bias kalman filter. No dependencies.
package gbkf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_NOISE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 3'd5;

  typedef struct packed {
    logic signed [31:0] gyro_rate;
    logic signed [31:0] angle_ref;
  } in_t;

  typedef struct packed {
    logic signed [31:0] angle_est;
    logic signed [31:0] rate_est;
    logic signed [31:0] bias_est;
    logic               singular;
  } out_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_JZ  = 3'd4,
    OP_END = 3'd5
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  localparam int SLOT_W       = 6;
  localparam int MEM_DEPTH    = 64;
  localparam int NUM_PERSIST  = 12;

  // scratch file slots
  localparam logic [SLOT_W-1:0] S_A   = 6'd0;
  localparam logic [SLOT_W-1:0] S_R   = 6'd1;
  localparam logic [SLOT_W-1:0] S_B   = 6'd2;
  localparam logic [SLOT_W-1:0] S_P0  = 6'd3;
  localparam logic [SLOT_W-1:0] S_P1  = 6'd4;
  localparam logic [SLOT_W-1:0] S_P2  = 6'd5;
  localparam logic [SLOT_W-1:0] S_P3  = 6'd6;
  localparam logic [SLOT_W-1:0] S_P4  = 6'd7;
  localparam logic [SLOT_W-1:0] S_P5  = 6'd8;
  localparam logic [SLOT_W-1:0] S_P6  = 6'd9;
  localparam logic [SLOT_W-1:0] S_P7  = 6'd10;
  localparam logic [SLOT_W-1:0] S_P8  = 6'd11;
  localparam logic [SLOT_W-1:0] S_T1  = 6'd12;
  localparam logic [SLOT_W-1:0] S_T2  = 6'd13;
  localparam logic [SLOT_W-1:0] S_T3  = 6'd14;
  localparam logic [SLOT_W-1:0] S_Q1  = 6'd15;
  localparam logic [SLOT_W-1:0] S_X   = 6'd16;
  localparam logic [SLOT_W-1:0] S_Y   = 6'd17;
  localparam logic [SLOT_W-1:0] S_S11 = 6'd18;
  localparam logic [SLOT_W-1:0] S_S12 = 6'd19;
  localparam logic [SLOT_W-1:0] S_S21 = 6'd20;
  localparam logic [SLOT_W-1:0] S_S22 = 6'd21;
  localparam logic [SLOT_W-1:0] S_D   = 6'd22;
  localparam logic [SLOT_W-1:0] S_T11 = 6'd23;
  localparam logic [SLOT_W-1:0] S_T12 = 6'd24;
  localparam logic [SLOT_W-1:0] S_T21 = 6'd25;
  localparam logic [SLOT_W-1:0] S_T22 = 6'd26;
  localparam logic [SLOT_W-1:0] S_H1  = 6'd27;
  localparam logic [SLOT_W-1:0] S_H2  = 6'd28;
  localparam logic [SLOT_W-1:0] S_K10 = 6'd29;
  localparam logic [SLOT_W-1:0] S_K11 = 6'd30;
  localparam logic [SLOT_W-1:0] S_K12 = 6'd31;
  localparam logic [SLOT_W-1:0] S_K20 = 6'd32;
  localparam logic [SLOT_W-1:0] S_K21 = 6'd33;
  localparam logic [SLOT_W-1:0] S_K22 = 6'd34;
  localparam logic [SLOT_W-1:0] S_E0  = 6'd35;
  localparam logic [SLOT_W-1:0] S_E1  = 6'd36;
  localparam logic [SLOT_W-1:0] S_E2  = 6'd37;
  localparam logic [SLOT_W-1:0] S_I1  = 6'd38;
  localparam logic [SLOT_W-1:0] S_I2  = 6'd39;
  // operands that come from registers or a constant rather than the file
  localparam logic [SLOT_W-1:0] S_DT   = 6'd48;
  localparam logic [SLOT_W-1:0] S_ANG  = 6'd49;
  localparam logic [SLOT_W-1:0] S_QR   = 6'd50;
  localparam logic [SLOT_W-1:0] S_QB   = 6'd51;
  localparam logic [SLOT_W-1:0] S_GN   = 6'd52;
  localparam logic [SLOT_W-1:0] S_AN   = 6'd53;
  localparam logic [SLOT_W-1:0] S_Z1   = 6'd54;
  localparam logic [SLOT_W-1:0] S_ZR   = 6'd55;
  localparam logic [SLOT_W-1:0] S_ZERO = 6'd56;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] dst;
    logic [SLOT_W-1:0] a;
    logic [SLOT_W-1:0] b;
  } uop_t;

  function automatic uop_t mk(op_e op, logic [SLOT_W-1:0] d, logic [SLOT_W-1:0] a,
                              logic [SLOT_W-1:0] b);
    uop_t u;
    u.op  = op;
    u.dst = d;
    u.a   = a;
    u.b   = b;
    return u;
  endfunction

  localparam int PROG_LEN = 121;
  localparam int PC_W     = 7;

  localparam uop_t PROG [PROG_LEN] = '{
    // prediction
    mk(OP_MUL, S_Q1, S_ANG, S_DT),
    mk(OP_SUB, S_R, S_Z1, S_B),
    mk(OP_MUL, S_X, S_DT, S_R),
    mk(OP_ADD, S_A, S_A, S_X),
    mk(OP_MUL, S_X, S_DT, S_P6),
    mk(OP_SUB, S_T1, S_P0, S_X),
    mk(OP_MUL, S_X, S_DT, S_P8),
    mk(OP_SUB, S_T2, S_P2, S_X),
    mk(OP_SUB, S_T3, S_P6, S_X),
    mk(OP_MUL, S_X, S_Q1, S_Q1),
    mk(OP_ADD, S_X, S_X, S_T1),
    mk(OP_MUL, S_Y, S_DT, S_T2),
    mk(OP_SUB, S_P0, S_X, S_Y),
    mk(OP_MUL, S_X, S_Q1, S_QR),
    mk(OP_SUB, S_P1, S_X, S_T1),
    mk(OP_MUL, S_X, S_Q1, S_QB),
    mk(OP_ADD, S_P2, S_X, S_T2),
    mk(OP_MUL, S_X, S_QR, S_Q1),
    mk(OP_SUB, S_P3, S_X, S_T3),
    mk(OP_MUL, S_X, S_QR, S_QR),
    mk(OP_ADD, S_P4, S_X, S_P8),
    mk(OP_MUL, S_X, S_QR, S_QB),
    mk(OP_SUB, S_P5, S_X, S_P8),
    mk(OP_MUL, S_X, S_QB, S_Q1),
    mk(OP_ADD, S_P6, S_X, S_T3),
    mk(OP_MUL, S_X, S_QB, S_QR),
    mk(OP_SUB, S_P7, S_X, S_P8),
    mk(OP_MUL, S_X, S_QB, S_QB),
    mk(OP_ADD, S_P8, S_X, S_P8),
    // innovation covariance and determinant
    mk(OP_ADD, S_X, S_P4, S_P7),
    mk(OP_ADD, S_X, S_X, S_P5),
    mk(OP_ADD, S_X, S_X, S_P8),
    mk(OP_ADD, S_S11, S_X, S_GN),
    mk(OP_ADD, S_S12, S_P3, S_P6),
    mk(OP_ADD, S_S21, S_P1, S_P2),
    mk(OP_ADD, S_S22, S_P0, S_AN),
    mk(OP_MUL, S_X, S_S11, S_S22),
    mk(OP_MUL, S_Y, S_S12, S_S21),
    mk(OP_SUB, S_D, S_X, S_Y),
    mk(OP_JZ,  S_X, S_D, S_D),
    // inverse
    mk(OP_DIV, S_T11, S_S22, S_D),
    mk(OP_SUB, S_X, S_ZERO, S_S12),
    mk(OP_DIV, S_T12, S_X, S_D),
    mk(OP_SUB, S_X, S_ZERO, S_S21),
    mk(OP_DIV, S_T21, S_X, S_D),
    mk(OP_DIV, S_T22, S_S11, S_D),
    // gains, h0 equals s21
    mk(OP_ADD, S_H1, S_P4, S_P5),
    mk(OP_ADD, S_H2, S_P7, S_P8),
    mk(OP_MUL, S_X, S_P0, S_T21),
    mk(OP_MUL, S_Y, S_S21, S_T11),
    mk(OP_ADD, S_K10, S_X, S_Y),
    mk(OP_MUL, S_X, S_P0, S_T22),
    mk(OP_MUL, S_Y, S_S21, S_T12),
    mk(OP_ADD, S_K20, S_X, S_Y),
    mk(OP_MUL, S_X, S_P3, S_T21),
    mk(OP_MUL, S_Y, S_H1, S_T11),
    mk(OP_ADD, S_K11, S_X, S_Y),
    mk(OP_MUL, S_X, S_P3, S_T22),
    mk(OP_MUL, S_Y, S_H1, S_T12),
    mk(OP_ADD, S_K21, S_X, S_Y),
    mk(OP_MUL, S_X, S_P6, S_T21),
    mk(OP_MUL, S_Y, S_H2, S_T11),
    mk(OP_ADD, S_K12, S_X, S_Y),
    mk(OP_MUL, S_X, S_P6, S_T22),
    mk(OP_MUL, S_Y, S_H2, S_T12),
    mk(OP_ADD, S_K22, S_X, S_Y),
    // innovations
    mk(OP_SUB, S_X, S_Z1, S_R),
    mk(OP_SUB, S_I1, S_X, S_B),
    mk(OP_SUB, S_I2, S_ZR, S_A),
    // state correction
    mk(OP_MUL, S_X, S_K10, S_I1),
    mk(OP_MUL, S_Y, S_K20, S_I2),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_ADD, S_A, S_A, S_X),
    mk(OP_MUL, S_X, S_K11, S_I1),
    mk(OP_MUL, S_Y, S_K21, S_I2),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_ADD, S_R, S_R, S_X),
    mk(OP_MUL, S_X, S_K12, S_I1),
    mk(OP_MUL, S_Y, S_K22, S_I2),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_ADD, S_B, S_B, S_X),
    // covariance correction, rows 2 and 1 before row 0
    mk(OP_ADD, S_E0, S_P3, S_P6),
    mk(OP_ADD, S_E1, S_P4, S_P7),
    mk(OP_ADD, S_E2, S_P5, S_P8),
    mk(OP_MUL, S_X, S_K22, S_P0),
    mk(OP_MUL, S_Y, S_K12, S_E0),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_SUB, S_P6, S_P6, S_X),
    mk(OP_MUL, S_X, S_K22, S_P1),
    mk(OP_MUL, S_Y, S_K12, S_E1),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_SUB, S_P7, S_P7, S_X),
    mk(OP_MUL, S_X, S_K22, S_P2),
    mk(OP_MUL, S_Y, S_K12, S_E2),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_SUB, S_P8, S_P8, S_X),
    mk(OP_MUL, S_X, S_K21, S_P0),
    mk(OP_MUL, S_Y, S_K11, S_E0),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_SUB, S_P3, S_P3, S_X),
    mk(OP_MUL, S_X, S_K21, S_P1),
    mk(OP_MUL, S_Y, S_K11, S_E1),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_SUB, S_P4, S_P4, S_X),
    mk(OP_MUL, S_X, S_K21, S_P2),
    mk(OP_MUL, S_Y, S_K11, S_E2),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_SUB, S_P5, S_P5, S_X),
    mk(OP_MUL, S_X, S_K20, S_P0),
    mk(OP_MUL, S_Y, S_K10, S_E0),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_SUB, S_P0, S_P0, S_X),
    mk(OP_MUL, S_X, S_K20, S_P1),
    mk(OP_MUL, S_Y, S_K10, S_E1),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_SUB, S_P1, S_P1, S_X),
    mk(OP_MUL, S_X, S_K20, S_P2),
    mk(OP_MUL, S_Y, S_K10, S_E2),
    mk(OP_ADD, S_X, S_X, S_Y),
    mk(OP_SUB, S_P2, S_P2, S_X),
    mk(OP_END, S_X, S_X, S_X)
  };

endpackage

FILE: hw/rtl/gbkf_alu.sv
// gbkf_alu: shared saturating add/sub, chunked multiplier and restoring
// divider for signed fixed point. Depends on gbkf_pkg.
module gbkf_alu #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gbkf_pkg::alu_req_t           req_i,
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] res_o
);
  import gbkf_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int CH  = 16;
  localparam int NCH = (DW + CH - 1) / CH;
  localparam int BW  = NCH * CH;
  localparam int PW  = 2 * DW;
  localparam int NW  = DW + FRAC_BITS;
  localparam int RW  = DW + 1;
  localparam int CW  = $clog2(NW + 1);

  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [PW-1:0] LIM_POS = PW'(VMAX);
  localparam logic [PW-1:0] LIM_NEG = PW'(VMAX) + PW'(1);
  localparam logic [PW-1:0] RND     = PW'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIN  = 4'b1000
  } alu_state_e;

  alu_state_e         st_q;
  logic [DW-1:0]      ua_q, ud_q;
  logic [BW-1:0]      ub_q;
  logic               neg_q, mul_q, done_q;
  logic [PW-1:0]      acc_q;
  logic [NW-1:0]      num_q, quo_q;
  logic [RW-1:0]      rem_q;
  logic [CW-1:0]      cnt_q;
  logic signed [DW-1:0] res_q;

  logic [DW-1:0]    mag_a, mag_b;
  logic [DW+CH-1:0] prod;
  logic [RW-1:0]    rem_sh;
  logic             quo_bit;
  logic [PW-1:0]    fin_mag, fin_lim, fin_sat;
  logic [DW:0]      sum_ext, dif_ext;
  logic [DW-1:0]    sum_sat, dif_sat;

  assign mag_a = a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
  assign mag_b = b_i[DW-1] ? DW'(-b_i) : DW'(b_i);
  assign prod  = ua_q * ub_q[BW-1 -: CH];

  assign rem_sh  = {rem_q[RW-2:0], num_q[NW-1]};
  assign quo_bit = rem_sh >= {1'b0, ud_q};

  assign fin_mag = mul_q ? ((acc_q + RND) >> FRAC_BITS) : PW'(quo_q);
  assign fin_lim = neg_q ? LIM_NEG : LIM_POS;
  assign fin_sat = (fin_mag > fin_lim) ? fin_lim : fin_mag;

  // overflow when the two top bits of the extended result differ
  assign sum_ext = {a_i[DW-1], a_i} + {b_i[DW-1], b_i};
  assign dif_ext = {a_i[DW-1], a_i} - {b_i[DW-1], b_i};
  assign sum_sat = (sum_ext[DW] != sum_ext[DW-1]) ? (sum_ext[DW] ? VMIN : VMAX)
                                                  : sum_ext[DW-1:0];
  assign dif_sat = (dif_ext[DW] != dif_ext[DW-1]) ? (dif_ext[DW] ? VMIN : VMAX)
                                                  : dif_ext[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        A_IDLE: begin
          if (req_i.start) begin
            case (req_i.op)
              OP_ADD: begin
                done_q <= 1'b1;
              end
              OP_SUB: begin
                done_q <= 1'b1;
              end
              OP_MUL: begin
                cnt_q <= '0;
                st_q  <= A_MUL;
              end
              OP_DIV: begin
                cnt_q <= '0;
                st_q  <= A_DIV;
              end
              default: ;
            endcase
          end
        end
        A_MUL: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(NCH - 1)) st_q <= A_FIN;
        end
        A_DIV: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(NW - 1)) st_q <= A_FIN;
        end
        A_FIN: begin
          done_q <= 1'b1;
          st_q   <= A_IDLE;
        end
        default: st_q <= A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      A_IDLE: begin
        if (req_i.start) begin
          neg_q <= a_i[DW-1] ^ b_i[DW-1];
          case (req_i.op)
            OP_ADD: res_q <= sum_sat;
            OP_SUB: res_q <= dif_sat;
            OP_MUL: begin
              ua_q  <= mag_a;
              ub_q  <= BW'(mag_b);
              acc_q <= '0;
              mul_q <= 1'b1;
            end
            OP_DIV: begin
              // numerator carries the half-divisor rounding term
              num_q <= (NW'(mag_a) << FRAC_BITS) + NW'(mag_b >> 1);
              ud_q  <= mag_b;
              rem_q <= '0;
              quo_q <= '0;
              mul_q <= 1'b0;
            end
            default: ;
          endcase
        end
      end
      A_MUL: begin
        acc_q <= (acc_q << CH) + PW'(prod);
        ub_q  <= ub_q << CH;
      end
      A_DIV: begin
        rem_q <= quo_bit ? (rem_sh - {1'b0, ud_q}) : rem_sh;
        quo_q <= {quo_q[NW-2:0], quo_bit};
        num_q <= num_q << 1;
      end
      A_FIN: begin
        res_q <= neg_q ? DW'(-fin_sat[DW-1:0]) : fin_sat[DW-1:0];
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: hw/rtl/gyro_bias_kalman_filter.sv
// gyro_bias_kalman_filter: three-state angle/rate/bias kalman filter, run by
// a micro-program over a scratch file and one shared arithmetic unit.
// Depends on gbkf_pkg and gbkf_alu.
//
//   channel | signals                               | direction
//   in      | in_valid_i, in_ready_o, in_data_i     | gyro rate and angle reference word
//   out     | out_valid_o, out_ready_i, out_data_o  | angle, rate, bias and singular word
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i       | register writes, no read-back
//
// each word runs the 121-entry micro-program, one micro-op at a time, and
// skips to the final micro-op when the determinant is zero; adds, subtracts,
// chunked multiplies and divides all share the single arithmetic unit.
// after reset a pass clears the twelve state slots before in_ready_o rises.
// in_ready_o is high only while the sequencer idles; a result that is not
// taken holds the sequencer on its final micro-op.
module gyro_bias_kalman_filter #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  gbkf_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gbkf_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [gbkf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gbkf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import gbkf_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int EW = ((DW > 32) ? DW : 32) + 1;
  localparam int CLR_W = $clog2(NUM_PERSIST);

  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [EW-1:0] VMAX_E = EW'($signed({1'b0, VMAX}));
  localparam logic signed [EW-1:0] VMIN_E = -VMAX_E - EW'(1);
  localparam logic signed [EW-1:0] OMAX_E = EW'(32'sh7fffffff);
  localparam logic signed [EW-1:0] OMIN_E = EW'(32'sh80000000);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_ISSUE = 5'b01000,
    ST_WAIT  = 5'b10000
  } seq_state_e;

  function automatic logic signed [DW-1:0] reg_val(input logic [CFG_DATA_W-1:0] r);
    logic signed [EW-1:0] v;
    v = EW'($signed({1'b0, r}));
    if (v > VMAX_E) return $signed(VMAX);
    return v[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_in(input logic signed [31:0] x);
    logic signed [EW-1:0] v;
    v = EW'(x);
    if (v > VMAX_E) v = VMAX_E;
    if (v < VMIN_E) v = VMIN_E;
    return v[DW-1:0];
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [DW-1:0] s);
    logic signed [EW-1:0] v;
    v = EW'(s);
    if (v > OMAX_E) v = OMAX_E;
    if (v < OMIN_E) v = OMIN_E;
    return v[31:0];
  endfunction

  seq_state_e              st_q;
  logic [PC_W-1:0]         pc_q;
  logic [CLR_W-1:0]        clr_q;
  logic [16:0]             step_q;
  logic [19:0]             ang_gain_q, rate_gain_q, bias_gain_q;
  logic [30:0]             gyro_noise_q, ang_noise_q;
  logic signed [DW-1:0]    z1_q, zr_q;
  logic signed [DW-1:0]    ang_q, rate_q, bias_q;
  logic                    sing_q;
  logic                    out_valid_q;
  out_t                    out_q;

  logic signed [DW-1:0]    mem_q [MEM_DEPTH];
  logic signed [DW-1:0]    rd_a_q, rd_b_q;

  uop_t                    uop;
  logic signed [DW-1:0]    opa, opb;
  alu_req_t                alu_req;
  logic                    alu_done;
  logic signed [DW-1:0]    alu_res;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_waddr;
  logic signed [DW-1:0]    mem_wdata;
  logic                    in_fire, out_load;

  assign uop = PROG[pc_q];

  always_comb begin
    case (uop.a)
      S_DT:    opa = reg_val(CFG_DATA_W'(step_q));
      S_ANG:   opa = reg_val(CFG_DATA_W'(ang_gain_q));
      S_QR:    opa = reg_val(CFG_DATA_W'(rate_gain_q));
      S_QB:    opa = reg_val(CFG_DATA_W'(bias_gain_q));
      S_GN:    opa = reg_val(gyro_noise_q);
      S_AN:    opa = reg_val(ang_noise_q);
      S_Z1:    opa = z1_q;
      S_ZR:    opa = zr_q;
      S_ZERO:  opa = '0;
      default: opa = rd_a_q;
    endcase
  end

  always_comb begin
    case (uop.b)
      S_DT:    opb = reg_val(CFG_DATA_W'(step_q));
      S_ANG:   opb = reg_val(CFG_DATA_W'(ang_gain_q));
      S_QR:    opb = reg_val(CFG_DATA_W'(rate_gain_q));
      S_QB:    opb = reg_val(CFG_DATA_W'(bias_gain_q));
      S_GN:    opb = reg_val(gyro_noise_q);
      S_AN:    opb = reg_val(ang_noise_q);
      S_Z1:    opb = z1_q;
      S_ZR:    opb = zr_q;
      S_ZERO:  opb = '0;
      default: opb = rd_b_q;
    endcase
  end

  assign alu_req.start = (st_q == ST_ISSUE) &&
                         (uop.op == OP_ADD || uop.op == OP_SUB ||
                          uop.op == OP_MUL || uop.op == OP_DIV);
  assign alu_req.op    = uop.op;

  gbkf_alu #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (opa),
    .b_i    (opb),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (st_q == ST_ISSUE) && (uop.op == OP_END) &&
                      (!out_valid_q || out_ready_i);

  assign mem_we    = (st_q == ST_CLEAR) || ((st_q == ST_WAIT) && alu_done);
  assign mem_waddr = (st_q == ST_CLEAR) ? SLOT_W'(clr_q) : uop.dst;
  assign mem_wdata = (st_q == ST_CLEAR) ? '0 : alu_res;

  // scratch file: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_a_q <= mem_q[uop.a];
    rd_b_q <= mem_q[uop.b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= 17'd66;
      ang_gain_q   <= 20'd13107;
      rate_gain_q  <= 20'd13107;
      bias_gain_q  <= 20'd6554;
      gyro_noise_q <= '0;
      ang_noise_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEP_TIME:   step_q       <= cfg_data_i[16:0];
        REG_ANGLE_GAIN:  ang_gain_q   <= cfg_data_i[19:0];
        REG_RATE_GAIN:   rate_gain_q  <= cfg_data_i[19:0];
        REG_BIAS_GAIN:   bias_gain_q  <= cfg_data_i[19:0];
        REG_GYRO_NOISE:  gyro_noise_q <= cfg_data_i;
        REG_ANGLE_NOISE: ang_noise_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      pc_q        <= '0;
      clr_q       <= '0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ang_q       <= '0;
      rate_q      <= '0;
      bias_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        ST_CLEAR: begin
          clr_q <= clr_q + CLR_W'(1);
          if (clr_q == CLR_W'(NUM_PERSIST - 1)) st_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire) begin
            pc_q   <= '0;
            sing_q <= 1'b0;
            st_q   <= ST_FETCH;
          end
        end
        ST_FETCH: st_q <= ST_ISSUE;
        ST_ISSUE: begin
          case (uop.op)
            OP_END: begin
              if (out_load) begin
                out_valid_q <= 1'b1;
                st_q        <= ST_IDLE;
              end
            end
            OP_JZ: begin
              // singular innovation covariance: keep the prediction
              if (opa == '0) begin
                sing_q <= 1'b1;
                pc_q   <= PC_W'(PROG_LEN - 1);
              end else begin
                pc_q <= pc_q + PC_W'(1);
              end
              st_q <= ST_FETCH;
            end
            default: st_q <= ST_WAIT;
          endcase
        end
        ST_WAIT: begin
          if (alu_done) begin
            if (uop.dst == S_A) ang_q  <= alu_res;
            if (uop.dst == S_R) rate_q <= alu_res;
            if (uop.dst == S_B) bias_q <= alu_res;
            pc_q <= pc_q + PC_W'(1);
            st_q <= ST_FETCH;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      z1_q <= sat_in(in_data_i.gyro_rate);
      zr_q <= sat_in(in_data_i.angle_ref);
    end
    if (out_load) begin
      out_q.angle_est <= sat_out(ang_q);
      out_q.rate_est  <= sat_out(rate_q);
      out_q.bias_est  <= sat_out(bias_q);
      out_q.singular  <= sing_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> st_q == ST_WAIT)
    else $error("arithmetic unit finished outside the wait state");

  a_out_from_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(st_q == ST_ISSUE && uop.op == OP_END))
    else $error("result word raised without the final micro-op");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pc_q) < PROG_LEN)
    else $error("micro-program counter out of range");

  a_ready_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !alu_req.start)
    else $error("arithmetic unit started while idle");
`endif

endmodule

FILE: tb/tb_gyro_bias_kalman_filter.sv
// tb_gyro_bias_kalman_filter: self-checking testbench for the gyro bias kalman
// filter; predicts angle, rate and bias per word in Q16.16. Depends on gbkf_pkg.
`timescale 1ns / 100ps

module tb_gyro_bias_kalman_filter;
  import gbkf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 8000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gyro_bias_kalman_filter DUT (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // filter state and registers as the block should hold them
  longint est_angle, est_rate, est_bias;
  longint est_cov [9];
  longint dt_reg, ang_gain, rate_gain, bias_gain, gyro_noise, ref_noise;

  out_t pending_words [$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int singular_seen = 0;
  bit quiet = 1'b0;
  int holdoff_cycles = 0;
  int idle_count = 0;

  function automatic longint sat(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint qadd(longint a, longint b);
    return sat(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return sat(a - b);
  endfunction

  function automatic longint signed_round(bit neg, bit [63:0] m);
    bit [63:0] lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint qmul(longint a, longint b);
    bit [63:0] ua, ub;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    return signed_round((a < 0) != (b < 0), (ua * ub + 64'd32768) >> 16);
  endfunction

  function automatic longint qdiv(longint a, longint d);
    bit [63:0] ua, ud;
    ua = (a < 0) ? -a : a;
    ud = (d < 0) ? -d : d;
    return signed_round((a < 0) != (d < 0), ((ua << 16) + (ud >> 1)) / ud);
  endfunction

  // one filter step: prediction then two-measurement update, skipped on a zero determinant
  function automatic out_t kalman_step(in_t w);
    longint z1, zr, q0, t1, t2, t3, t4, s11, s12, s21, s22, det;
    longint t11, t12, t21, t22, i1, i2;
    longint p [9];
    longint np [9];
    longint h [3];
    longint k1 [3];
    longint k2 [3];
    longint e [3];
    out_t r;
    z1 = w.gyro_rate;
    zr = w.angle_ref;
    q0 = qmul(ang_gain, dt_reg);
    p = est_cov;
    est_rate = qsub(z1, est_bias);
    est_angle = qadd(est_angle, qmul(dt_reg, est_rate));
    t1 = qsub(p[0], qmul(dt_reg, p[6]));
    t2 = qsub(p[2], qmul(dt_reg, p[8]));
    t3 = qsub(p[6], qmul(dt_reg, p[8]));
    t4 = p[8];
    np[0] = qsub(qadd(qmul(q0, q0), t1), qmul(dt_reg, t2));
    np[1] = qsub(qmul(q0, rate_gain), t1);
    np[2] = qadd(qmul(q0, bias_gain), t2);
    np[3] = qsub(qmul(rate_gain, q0), t3);
    np[4] = qadd(qmul(rate_gain, rate_gain), t4);
    np[5] = qsub(qmul(rate_gain, bias_gain), t4);
    np[6] = qadd(qmul(bias_gain, q0), t3);
    np[7] = qsub(qmul(bias_gain, rate_gain), t4);
    np[8] = qadd(qmul(bias_gain, bias_gain), t4);
    p = np;
    s11 = qadd(qadd(qadd(qadd(p[4], p[7]), p[5]), p[8]), gyro_noise);
    s12 = qadd(p[3], p[6]);
    s21 = qadd(p[1], p[2]);
    s22 = qadd(p[0], ref_noise);
    det = qsub(qmul(s11, s22), qmul(s12, s21));
    r.singular = (det == 0);
    if (det != 0) begin
      t11 = qdiv(s22, det);
      t12 = qdiv(qsub(0, s12), det);
      t21 = qdiv(qsub(0, s21), det);
      t22 = qdiv(s11, det);
      h[0] = qadd(p[1], p[2]);
      h[1] = qadd(p[4], p[5]);
      h[2] = qadd(p[7], p[8]);
      for (int i = 0; i < 3; i++) begin
        k1[i] = qadd(qmul(p[3*i], t21), qmul(h[i], t11));
        k2[i] = qadd(qmul(p[3*i], t22), qmul(h[i], t12));
      end
      i1 = qsub(qsub(z1, est_rate), est_bias);
      i2 = qsub(zr, est_angle);
      est_angle = qadd(est_angle, qadd(qmul(k1[0], i1), qmul(k2[0], i2)));
      est_rate = qadd(est_rate, qadd(qmul(k1[1], i1), qmul(k2[1], i2)));
      est_bias = qadd(est_bias, qadd(qmul(k1[2], i1), qmul(k2[2], i2)));
      for (int j = 0; j < 3; j++) e[j] = qadd(p[3+j], p[6+j]);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          np[3*i+j] = qsub(p[3*i+j], qadd(qmul(k2[i], p[j]), qmul(k1[i], e[j])));
        end
      end
      p = np;
    end
    est_cov = p;
    r.angle_est = est_angle[31:0];
    r.rate_est = est_rate[31:0];
    r.bias_est = est_bias[31:0];
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %0s: got %0d, want %0d", what, $signed(got), $signed(want));
  endtask

  // register writes; callers must issue them only while the filter is idle, the task does not enforce it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_STEP_TIME:   dt_reg = val[16:0];
      REG_ANGLE_GAIN:  ang_gain = val[19:0];
      REG_RATE_GAIN:   rate_gain = val[19:0];
      REG_BIAS_GAIN:   bias_gain = val[19:0];
      REG_GYRO_NOISE:  gyro_noise = val[30:0];
      REG_ANGLE_NOISE: ref_noise = val[30:0];
      default: ;
    endcase
  endtask

  task automatic configure(int st, int ag, int rg, int bg, int gn, int an);
    write_reg(REG_STEP_TIME, st);
    write_reg(REG_ANGLE_GAIN, ag);
    write_reg(REG_RATE_GAIN, rg);
    write_reg(REG_BIAS_GAIN, bg);
    write_reg(REG_GYRO_NOISE, gn);
    write_reg(REG_ANGLE_NOISE, an);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // the last word is already taken; stop offering it, await all pending results
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic send_word(logic [31:0] gyro, logic [31:0] ref_angle);
    int gap;
    gap = quiet ? 0 : $urandom_range(18, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{gyro_rate: gyro, angle_ref: ref_angle};
    do @(posedge clk_i); while (!in_ready_o);
    pending_words.push_back(kalman_step(in_data_i));
    words_sent++;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3, 0))
      0: return $urandom();
      1: return $urandom_range(262144, 0) - 131072;
      2: return $urandom_range(8, 0) - 4;
      default: return $urandom_range(6553600, 0) - 3276800;
    endcase
  endfunction

  task automatic random_words(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(3, 0) == 0);
      send_word(rand_sample(), rand_sample());
    end
    quiet = 1'b0;
  endtask

  // receive side
  initial begin
    int stall;
    forever begin
      if (holdoff_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (holdoff_cycles) @(posedge clk_i);
        holdoff_cycles = 0;
      end else begin
        stall = quiet ? 0 : $urandom_range(18, 0);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_words.size() == 0) begin
        report("unexpected word angle", out_data_o.angle_est, 32'd0);
      end else begin
        out_t want;
        want = pending_words.pop_front();
        if (out_data_o.angle_est !== want.angle_est)
          report("angle_est", out_data_o.angle_est, want.angle_est);
        if (out_data_o.rate_est !== want.rate_est)
          report("rate_est", out_data_o.rate_est, want.rate_est);
        if (out_data_o.bias_est !== want.bias_est)
          report("bias_est", out_data_o.bias_est, want.bias_est);
        if (out_data_o.singular !== want.singular)
          report("singular", out_data_o.singular, want.singular);
        if (want.singular) singular_seen++;
        words_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_count);
      $display("tb_gyro_bias_kalman_filter: done, errors");
      $finish;
    end
  end

  task automatic test_defaults();
    send_word(32'sh7FFFFFFF, 32'sh80000000);
    send_word(32'sh80000000, 32'sh7FFFFFFF);
    send_word(32'd0, 32'd0);
    send_word(32'sh00010000, 32'sh00008000);
    send_word(32'shFFFFFFFF, 32'sd1);
    drain();
  endtask

  task automatic test_singular();
    // zero gains and noise make the innovation covariance singular
    configure(66, 0, 0, 0, 0, 0);
    send_word(32'sh00020000, 32'sh00010000);
    send_word(32'sh80000000, 32'sh7FFFFFFF);
    send_word(32'shFFFF0000, 32'd0);
    drain();
  endtask

  task automatic test_extremes();
    configure(65536, 655360, 655360, 655360, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_word(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_word(32'sh80000000, 32'sh80000000);
    send_word(32'sh00010000, 32'shFFFF0000);
    drain();
    configure(1, 0, 655360, 1, 0, 32'h7FFFFFFF);
    send_word(32'sh7FFFFFFF, 32'sh80000000);
    send_word(32'sh12345678, 32'shEDCBA987);
    drain();
    configure(65536, 655360, 0, 0, 1, 1);
    send_word(32'sh00050000, 32'sh00030000);
    send_word(32'sh80000000, 32'sh7FFFFFFF);
    drain();
  endtask

  task automatic test_spare_index();
    write_reg(REG_SPARE, $urandom());
    write_reg(REG_SPARE + 3'd1, $urandom());
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_word(32'sh00010000, 32'sh00010000);
    drain();
  endtask

  task automatic test_random_phases();
    configure(66, 13107, 13107, 6554, 655, 6554);
    random_words(80);
    drain();
    configure($urandom_range(65536, 1), $urandom_range(655360, 0),
              $urandom_range(655360, 0), $urandom_range(655360, 0),
              $urandom(), $urandom());
    random_words(80);
    drain();
    configure($urandom_range(1024, 1), $urandom_range(65536, 0),
              $urandom_range(65536, 0), $urandom_range(65536, 0),
              $urandom_range(65536, 0), $urandom_range(65536, 0));
    random_words(80);
    drain();
  endtask

  task automatic test_backpressure();
    configure(656, 13107, 13107, 6554, 3277, 3277);
    holdoff_cycles = 2500;
    random_words(60);
    drain();
    random_words(60);
  endtask

  initial begin
    est_angle = 0;
    est_rate = 0;
    est_bias = 0;
    foreach (est_cov[i]) est_cov[i] = 0;
    dt_reg = 66;
    ang_gain = 13107;
    rate_gain = 13107;
    bias_gain = 6554;
    gyro_noise = 0;
    ref_noise = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_singular();
    test_extremes();
    test_spare_index();
    test_random_phases();
    test_backpressure();
    drain();
    $display("%0d words sent, %0d checked, %0d with a singular update, %0d mismatches",
             words_sent, words_checked, singular_seen, errors);
    $display("covered default, zero-noise, saturating and random register settings");
    if (errors == 0 && pending_words.size() == 0) begin
      $display("tb_gyro_bias_kalman_filter: done, clean");
    end else begin
      $display("tb_gyro_bias_kalman_filter: done, errors");
    end
    $finish;
  end

endmodule
